/* rtl/core/lobm_pkg.sv */
// Package for the limit order book matcher: field widths, book entry type,
// event codes, controller states and the command/status structs. No dependencies.
`default_nettype none

package lobm_pkg;

  // Default number of slots in each book.
  localparam int unsigned BOOK_DEPTH_DEF = 32;

  // Field widths.
  localparam int unsigned PriceW = 32;
  localparam int unsigned QtyW   = 24;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IdW    = 32;
  localparam int unsigned OwnerW = 8;
  localparam int unsigned KindW  = 2;

  // Event codes carried on the result channel.
  localparam logic [KindW-1:0] EV_FILL = 2'd0;
  localparam logic [KindW-1:0] EV_REST = 2'd1;
  localparam logic [KindW-1:0] EV_DROP = 2'd2;

  // Book selectors within the shared entry memory.
  localparam logic BOOK_BID = 1'b0;
  localparam logic BOOK_ASK = 1'b1;

  // One resting order.
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [TimeW-1:0]  tstamp;
    logic [IdW-1:0]    order;
    logic [OwnerW-1:0] owner;
  } entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_FILL,
    ST_FREE,
    ST_REST
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming order
    logic idx_clr;    // restart the slot counter and forget the best entry
    logic scan_step;  // read the next slot of the opposite book
    logic fill;       // apply a fill against the best entry and emit it
    logic free_step;  // test the next slot of the own book for being free
    logic rest;       // rest or drop the remainder and emit the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_zero;    // incoming quantity is zero
    logic idx_last;   // slot counter is on the last slot
    logic best_vld;   // a crossing entry was found by the scan
    logic left_zero;  // the pending fill completes the order
    logic n_full;     // the pending fill is the last one allowed
    logic free_hit;   // current own slot is free
    logic out_free;   // output register can take a result this cycle
  } sts_t;

  // True when entry a strictly outranks entry b.
  function automatic logic outranks(entry_t a, entry_t b, logic high_first);
    logic r;
    if (a.price != b.price) begin
      r = high_first ? (a.price > b.price) : (a.price < b.price);
    end else if (a.tstamp != b.tstamp) begin
      r = a.tstamp < b.tstamp;
    end else begin
      r = a.qty > b.qty;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lobm_ctrl.sv */
// Controller state machine of the limit order book matcher.
// Depends on lobm_pkg; drives the datapath lobm_dp through cmd_t and reads sts_t.
`default_nettype none

module lobm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lobm_pkg::sts_t sts_i,
  output lobm_pkg::cmd_t      cmd_o
);
  import lobm_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_zero) begin
            state_d = ST_REST;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // The last read slot is ranked during this cycle.
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.best_vld) begin
          state_d = ST_FILL;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_FREE;
        end
      end
      ST_FILL: begin
        if (sts_i.out_free) begin
          cmd_o.fill = 1'b1;
          if (sts_i.left_zero) begin
            state_d = ST_IDLE;
          end else if (sts_i.n_full) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_FREE;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end
      ST_FREE: begin
        cmd_o.free_step = 1'b1;
        if (sts_i.free_hit || sts_i.idx_last) begin
          state_d = ST_REST;
        end
      end
      ST_REST: begin
        if (sts_i.out_free) begin
          cmd_o.rest = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/lobm_dp.sv */
// Datapath of the limit order book matcher: book memory, used bits, scan
// ranking, fill arithmetic and the output register. Depends on lobm_pkg.
`default_nettype none

module lobm_dp #(
  parameter int unsigned BookDepth = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lobm_pkg::cmd_t                cmd_i,
  output lobm_pkg::sts_t                     sts_o,
  input  wire logic                          buy_side_i,
  input  wire logic [lobm_pkg::PriceW-1:0]   limit_price_i,
  input  wire logic [lobm_pkg::QtyW-1:0]     order_quantity_i,
  input  wire logic [lobm_pkg::TimeW-1:0]    arrival_time_i,
  input  wire logic [lobm_pkg::IdW-1:0]      incoming_id_i,
  input  wire logic [lobm_pkg::OwnerW-1:0]   trader_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lobm_pkg::KindW-1:0]         event_kind_o,
  output logic [lobm_pkg::IdW-1:0]           aggressor_id_o,
  output logic [lobm_pkg::IdW-1:0]           counter_id_o,
  output logic [lobm_pkg::OwnerW-1:0]        counter_trader_o,
  output logic [lobm_pkg::PriceW-1:0]        fill_price_o,
  output logic [lobm_pkg::QtyW-1:0]          fill_quantity_o,
  output logic [lobm_pkg::QtyW-1:0]          left_quantity_o,
  output logic                               final_res_o
);
  import lobm_pkg::*;

  localparam int unsigned IdxW     = (BookDepth > 1) ? $clog2(BookDepth) : 1;
  localparam int unsigned CntW     = $clog2(BookDepth + 1);
  localparam int unsigned AddrW    = IdxW + 1;
  localparam int unsigned MemDepth = 2 * (2 ** IdxW);

  // Captured order.
  logic              buy_q;
  logic [PriceW-1:0] limit_q;
  logic [QtyW-1:0]   left_q;
  logic [TimeW-1:0]  time_q;
  logic [IdW-1:0]    id_q;
  logic [OwnerW-1:0] who_q;

  // Scan state.
  logic [IdxW-1:0]   idx_q;
  logic [CntW-1:0]   n_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  entry_t            rd_q;
  logic              best_vld_q;
  logic [IdxW-1:0]   best_idx_q;
  entry_t            best_q;
  logic              found_q;

  // Books: used bits in flops, entries in one memory split by book.
  logic [BookDepth-1:0] used_q [2];
  entry_t               mem [MemDepth];

  logic              opp_book, own_book;
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  entry_t            wr_data;
  logic              cand_cross, cand_take;
  logic [QtyW-1:0]   fq, left_after, best_rem;
  logic              out_free;

  assign opp_book = buy_q ? BOOK_ASK : BOOK_BID;
  assign own_book = buy_q ? BOOK_BID : BOOK_ASK;
  assign rd_addr  = {opp_book, idx_q};
  assign out_free = !out_valid_o || out_ready_i;

  // Ranking of the slot read in the previous cycle.
  always_comb begin
    cand_cross = buy_q ? (rd_q.price <= limit_q) : (rd_q.price >= limit_q);
    cand_take  = rd_vld_q && used_q[opp_book][rd_idx_q] && cand_cross &&
                 (!best_vld_q || outranks(rd_q, best_q, !buy_q));
  end

  // Fill arithmetic against the best entry.
  always_comb begin
    fq         = (best_q.qty < left_q) ? best_q.qty : left_q;
    left_after = left_q - fq;
    best_rem   = best_q.qty - fq;
  end

  // Memory write port: fill updates or a new resting entry.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {opp_book, best_idx_q};
    wr_data = best_q;
    if (cmd_i.fill) begin
      wr_en       = 1'b1;
      wr_data.qty = best_rem;
    end else if (cmd_i.rest && found_q) begin
      wr_en   = 1'b1;
      wr_addr = {own_book, idx_q};
      wr_data = '{price: limit_q, qty: left_q, tstamp: time_q, order: id_q, owner: who_q};
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Status to the controller.
  always_comb begin
    sts_o.in_zero   = (order_quantity_i == '0);
    sts_o.idx_last  = (idx_q == IdxW'(BookDepth - 1));
    sts_o.best_vld  = best_vld_q;
    sts_o.left_zero = (left_after == '0);
    sts_o.n_full    = (n_q == CntW'(BookDepth - 1));
    sts_o.free_hit  = !used_q[own_book][idx_q];
    sts_o.out_free  = out_free;
  end

  // Order capture and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      buy_q   <= buy_side_i;
      limit_q <= limit_price_i;
      left_q  <= order_quantity_i;
      time_q  <= arrival_time_i;
      id_q    <= incoming_id_i;
      who_q   <= trader_i;
    end else if (cmd_i.fill) begin
      left_q <= left_after;
    end
    rd_idx_q <= idx_q;
    if (cand_take) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // Control registers: counters, flags and used bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      n_q        <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      found_q    <= 1'b0;
      used_q[0]  <= '0;
      used_q[1]  <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.load) begin
        n_q     <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.idx_clr) begin
        idx_q      <= '0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
      end else if (cmd_i.free_step) begin
        found_q <= !used_q[own_book][idx_q];
        if (used_q[own_book][idx_q]) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cand_take) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.fill) begin
        n_q <= n_q + 1'b1;
        if (best_rem == '0) begin
          used_q[opp_book][best_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.rest && found_q) begin
        used_q[own_book][idx_q] <= 1'b1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.fill || cmd_i.rest) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      event_kind_o     <= EV_FILL;
      aggressor_id_o   <= id_q;
      counter_id_o     <= best_q.order;
      counter_trader_o <= best_q.owner;
      fill_price_o     <= best_q.price;
      fill_quantity_o  <= fq;
      left_quantity_o  <= left_after;
      final_res_o      <= (left_after == '0);
    end else if (cmd_i.rest) begin
      event_kind_o     <= found_q ? EV_REST : EV_DROP;
      aggressor_id_o   <= id_q;
      counter_id_o     <= '0;
      counter_trader_o <= '0;
      fill_price_o     <= '0;
      fill_quantity_o  <= '0;
      left_quantity_o  <= left_q;
      final_res_o      <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/limit_order_book_matcher.sv */
// Top level of the limit order book matcher.
// Depends on lobm_pkg, lobm_ctrl and lobm_dp.
`default_nettype none

// Price-time priority matcher with a bid book and an ask book of BookDepth
// slots each. Each transaction on the input channel is one limit order; it
// produces one or more result transactions, the last with final_res_o set.
// Every fill costs one scan of the opposite book, one memory read per slot
// through the single read port of the book memory. After a scan that finds
// no crossing entry, placing a remainder searches the order's own book for
// its lowest free slot. An order of zero quantity skips the scan. The
// result channel can stall the matcher at each result. Books are empty after
// reset; no clearing pass is needed.
module limit_order_book_matcher #(
  parameter int unsigned BookDepth = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          buy_side_i,
  input  wire logic [lobm_pkg::PriceW-1:0]   limit_price_i,
  input  wire logic [lobm_pkg::QtyW-1:0]     order_quantity_i,
  input  wire logic [lobm_pkg::TimeW-1:0]    arrival_time_i,
  input  wire logic [lobm_pkg::IdW-1:0]      incoming_id_i,
  input  wire logic [lobm_pkg::OwnerW-1:0]   trader_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lobm_pkg::KindW-1:0]         event_kind_o,
  output logic [lobm_pkg::IdW-1:0]           aggressor_id_o,
  output logic [lobm_pkg::IdW-1:0]           counter_id_o,
  output logic [lobm_pkg::OwnerW-1:0]        counter_trader_o,
  output logic [lobm_pkg::PriceW-1:0]        fill_price_o,
  output logic [lobm_pkg::QtyW-1:0]          fill_quantity_o,
  output logic [lobm_pkg::QtyW-1:0]          left_quantity_o,
  output logic                               final_res_o
);
  import lobm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of scans, fills and resting.
  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Books, ranking and result register.
  lobm_dp #(
    .BookDepth (BookDepth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .buy_side_i       (buy_side_i),
    .limit_price_i    (limit_price_i),
    .order_quantity_i (order_quantity_i),
    .arrival_time_i   (arrival_time_i),
    .incoming_id_i    (incoming_id_i),
    .trader_i         (trader_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .aggressor_id_o   (aggressor_id_o),
    .counter_id_o     (counter_id_o),
    .counter_trader_o (counter_trader_o),
    .fill_price_o     (fill_price_o),
    .fill_quantity_o  (fill_quantity_o),
    .left_quantity_o  (left_quantity_o),
    .final_res_o      (final_res_o)
  );

endmodule

`default_nettype wire
